// ===== hdl/lfcr_pkg.sv =====
`default_nettype none

package lfcr_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = 32;
    localparam int NUM_CNT      = 5;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;

    // event counter slots
    localparam int CNT_HDR  = 0;
    localparam int CNT_LEN  = 1;
    localparam int CNT_TAIL = 2;
    localparam int CNT_CRC  = 3;
    localparam int CNT_GOOD = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_VALUE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 3'd4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        ST_MORE = 3'd0,
        ST_OK   = 3'd1,
        ST_LEN  = 3'd2,
        ST_OVF  = 3'd3,
        ST_TAIL = 3'd4,
        ST_CRC  = 3'd5
    } status_t;

    typedef struct packed {
        status_t                          status;
        logic [7:0]                       command;
        logic [7:0]                       payload_length;
        logic [NUM_CNT-1:0][CNT_W-1:0]    counts;
    } parse_t;

    typedef struct packed {
        parse_t     parse;
        logic       is_read;
        logic       rd_ok;
    } pend_t;

    typedef struct packed {
        parse_t     parse;
        logic       is_read;
        logic [7:0] read_data;
    } result_t;

    // CRC-16/MODBUS, one byte, reflected
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lfcr_ram.sv =====
`default_nettype none

module lfcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lfcr_parser.sv =====
`default_nettype none

module lfcr_parser (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [lfcr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lfcr_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              feed_en,
    input  wire logic [7:0]                        rx_byte,
    output logic                                   wr_en,
    output logic [lfcr_pkg::ADDR_W-1:0]            wr_addr,
    output logic [7:0]                             wr_data,
    output lfcr_pkg::parse_t                       parse_out
);

    import lfcr_pkg::*;

    typedef enum logic [4:0] {
        PH_SEARCH = 5'b00001,
        PH_SECOND = 5'b00010,
        PH_LEN_LO = 5'b00100,
        PH_LEN_HI = 5'b01000,
        PH_BODY   = 5'b10000
    } phase_t;

    logic [7:0]  header_first_reg, header_second_reg, tail_value_reg;
    logic [15:0] min_length_reg, max_length_reg;

    phase_t                        phase_reg, phase_next;
    logic [ADDR_W-1:0]             pos_reg, pos_next;
    logic [ADDR_W-1:0]             len_reg, len_next;
    logic [7:0]                    len_low_reg, len_low_next;
    logic [15:0]                   crc_reg, crc_next;
    logic [7:0]                    prev1_reg, prev1_next;
    logic [7:0]                    prev2_reg, prev2_next;
    logic [7:0]                    cand_reg, cand_next;
    logic [7:0]                    cmd_reg, cmd_next;
    logic [7:0]                    plen_reg, plen_next;
    logic [NUM_CNT-1:0][CNT_W-1:0] cnt_reg, cnt_next;
    status_t                       status;
    logic [15:0]                   len_full;
    logic [15:0]                   plen_wide;

    assign len_full  = {rx_byte, len_low_reg};
    assign plen_wide = 16'(len_reg) - 16'd3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= 8'h55;
            header_second_reg <= 8'hAA;
            tail_value_reg    <= 8'h00;
            min_length_reg    <= 16'd3;
            max_length_reg    <= 16'd255;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HEADER_FIRST:  header_first_reg  <= cfg_data[7:0];
                CFG_HEADER_SECOND: header_second_reg <= cfg_data[7:0];
                CFG_TAIL_VALUE:    tail_value_reg    <= cfg_data[7:0];
                CFG_MIN_LENGTH:    min_length_reg    <= cfg_data;
                CFG_MAX_LENGTH:    max_length_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        len_low_next = len_low_reg;
        crc_next     = crc_reg;
        prev1_next   = prev1_reg;
        prev2_next   = prev2_reg;
        cand_next    = cand_reg;
        cmd_next     = cmd_reg;
        plen_next    = plen_reg;
        cnt_next     = cnt_reg;
        status       = ST_MORE;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = rx_byte;
        if (feed_en) begin
            case (phase_reg)
                PH_SEARCH: begin
                    if (rx_byte == header_first_reg) begin
                        phase_next = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    if (rx_byte == header_second_reg) begin
                        phase_next = PH_LEN_LO;
                    end else if (rx_byte != header_first_reg) begin
                        cnt_next[CNT_HDR] = cnt_reg[CNT_HDR] + 1'b1;
                        phase_next        = PH_SEARCH;
                    end
                end
                PH_LEN_LO: begin
                    len_low_next = rx_byte;
                    phase_next   = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    if (len_full < 16'd3 || len_full < min_length_reg ||
                        len_full > max_length_reg) begin
                        status = ST_LEN;
                    end else if (32'(len_full) >= BUFFER_BYTES) begin
                        status = ST_OVF;
                    end
                    if (status != ST_MORE) begin
                        cnt_next[CNT_LEN] = cnt_reg[CNT_LEN] + 1'b1;
                        plen_next         = 8'h00;
                        phase_next        = PH_SEARCH;
                    end else begin
                        len_next   = ADDR_W'(len_full);
                        pos_next   = '0;
                        crc_next   = CRC_INIT;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY: begin
                    wr_en      = 1'b1;
                    prev1_next = rx_byte;
                    prev2_next = prev1_reg;
                    if (pos_reg == '0) begin
                        cand_next = rx_byte;
                    end
                    if (pos_reg < len_reg - ADDR_W'(2)) begin
                        crc_next = crc_byte(crc_reg, rx_byte);
                    end
                    if (pos_reg != len_reg) begin
                        pos_next = pos_reg + 1'b1;
                    end else begin
                        // tail byte: CRC bytes are the two before it
                        phase_next = PH_SEARCH;
                        pos_next   = '0;
                        if (rx_byte != tail_value_reg) begin
                            status             = ST_TAIL;
                            cnt_next[CNT_TAIL] = cnt_reg[CNT_TAIL] + 1'b1;
                            plen_next          = 8'h00;
                        end else if ({prev1_reg, prev2_reg} != crc_reg) begin
                            status            = ST_CRC;
                            cnt_next[CNT_CRC] = cnt_reg[CNT_CRC] + 1'b1;
                            plen_next         = 8'h00;
                        end else begin
                            status             = ST_OK;
                            cnt_next[CNT_GOOD] = cnt_reg[CNT_GOOD] + 1'b1;
                            plen_next          = plen_wide[7:0];
                            cmd_next           = cand_reg;
                        end
                    end
                end
                default: begin
                    phase_next = PH_SEARCH;
                    pos_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SEARCH;
            pos_reg     <= '0;
            len_reg     <= '0;
            len_low_reg <= 8'h00;
            crc_reg     <= CRC_INIT;
            cmd_reg     <= 8'h00;
            plen_reg    <= 8'h00;
            cnt_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            len_low_reg <= len_low_next;
            crc_reg     <= crc_next;
            cmd_reg     <= cmd_next;
            plen_reg    <= plen_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev1_reg <= prev1_next;
        prev2_reg <= prev2_next;
        cand_reg  <= cand_next;
    end

    assign parse_out.status         = status;
    assign parse_out.command        = cmd_next;
    assign parse_out.payload_length = plen_next;
    assign parse_out.counts         = cnt_next;

endmodule

`default_nettype wire

// ===== hdl/length_framed_crc_receiver_core.sv =====
// Length-framed receiver with CRC-16/MODBUS check and body read-back.
//
// Input channel (s_*): one request per accepted beat. s_req_type 0 feeds
// s_rx_byte into the frame parser; s_req_type 1 reads the stored body byte
// at s_read_index. Every request yields exactly one result on m_*.
// Result: status of this request, command and payload length of the last good
// frame (payload length is zero after a length, tail or CRC error), the
// read-back byte, and the five wrapping event counters after this request.
// The parser settles the request in the accept cycle while the body RAM read
// is in flight; stage one registers it, and the result register loads from
// stage one once free. Throughput is one request per cycle while m_ready is
// high, set by the byte-wise CRC update and one RAM write or read per request.
// A stalled m_ready holds the result register; one further request is still
// taken into the RAM-read stage, after which s_ready drops until m_ready.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) are registered.
// Reset (aresetn low, synchronous) restores default registers, returns the
// parser to header search and clears all counters; body RAM contents stay
// undefined until written by a frame.
`default_nettype none

module length_framed_crc_receiver_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [lfcr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lfcr_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_req_type,
    input  wire logic [7:0]                        s_rx_byte,
    input  wire logic [7:0]                        s_read_index,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output lfcr_pkg::status_t                      m_status,
    output logic [7:0]                             m_frame_command,
    output logic [7:0]                             m_payload_length,
    output logic [7:0]                             m_read_data,
    output logic [lfcr_pkg::CNT_W-1:0]             m_header_errors,
    output logic [lfcr_pkg::CNT_W-1:0]             m_length_errors,
    output logic [lfcr_pkg::CNT_W-1:0]             m_tail_errors,
    output logic [lfcr_pkg::CNT_W-1:0]             m_crc_errors,
    output logic [lfcr_pkg::CNT_W-1:0]             m_good_frames
);

    import lfcr_pkg::*;

    logic              s_accept;
    logic              s1_adv;
    logic              s2_free;
    logic              feed_en;
    logic              rd_en;
    logic              rd_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        ram_rdata;
    parse_t            parse_out;

    logic    s1_valid_reg, s1_valid_next;
    pend_t   s1_reg, s1_next;
    logic    s2_valid_reg, s2_valid_next;
    result_t s2_reg, s2_next;

    assign s2_free  = !s2_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s_ready  = !s1_valid_reg || s2_free;
    assign s_accept = s_valid && s_ready;
    assign feed_en  = s_accept && !s_req_type;
    assign rd_en    = s_accept && s_req_type;
    assign rd_ok    = 32'(s_read_index) < BUFFER_BYTES;

    lfcr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .feed_en   (feed_en),
        .rx_byte   (s_rx_byte),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .parse_out (parse_out)
    );

    lfcr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_body_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (ADDR_W'(s_read_index)),
        .rdata (ram_rdata)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (s_accept) begin
            s1_valid_next   = 1'b1;
            s1_next.parse   = parse_out;
            s1_next.is_read = s_req_type;
            s1_next.rd_ok   = rd_ok;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    // RAM output holds while stage one stalls: no new read is issued then
    always_comb begin
        s2_valid_next = s2_valid_reg;
        s2_next       = s2_reg;
        if (s1_adv) begin
            s2_valid_next     = 1'b1;
            s2_next.parse     = s1_reg.parse;
            s2_next.is_read   = s1_reg.is_read;
            s2_next.read_data = (s1_reg.is_read && s1_reg.rd_ok) ? ram_rdata : 8'h00;
        end else if (m_ready) begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign m_valid          = s2_valid_reg;
    assign m_status         = s2_reg.parse.status;
    assign m_frame_command  = s2_reg.parse.command;
    assign m_payload_length = s2_reg.parse.payload_length;
    assign m_read_data      = s2_reg.read_data;
    assign m_header_errors  = s2_reg.parse.counts[CNT_HDR];
    assign m_length_errors  = s2_reg.parse.counts[CNT_LEN];
    assign m_tail_errors    = s2_reg.parse.counts[CNT_TAIL];
    assign m_crc_errors     = s2_reg.parse.counts[CNT_CRC];
    assign m_good_frames    = s2_reg.parse.counts[CNT_GOOD];

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s2_free) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("pending request changed while stalled");

    a_read_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && s2_reg.is_read) |-> (m_status == ST_MORE))
        else $error("read request carried a frame status");

    a_err_plen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_LEN || m_status == ST_OVF ||
                     m_status == ST_TAIL || m_status == ST_CRC))
        |-> (m_payload_length == 8'h00))
        else $error("payload length kept after a rejected frame");

    a_feed_no_rdata: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !s2_reg.is_read) |-> (m_read_data == 8'h00))
        else $error("feed request returned read data");

endmodule

`default_nettype wire
